// ----- rtl/core/cma_pkg.sv -----
package cma_pkg;

   localparam int MAX_RECTS_DEF    = 1024;
   localparam int SEARCH_LIMIT_DEF = 100;

   // pipeline depth of the height/area evaluator
   localparam int EVAL_LAT = 16;

   localparam logic signed [63:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;

   localparam logic [2:0] REG_COEF_A  = 3'd0;
   localparam logic [2:0] REG_COEF_B  = 3'd1;
   localparam logic [2:0] REG_COEF_C  = 3'd2;
   localparam logic [2:0] REG_COEF_D  = 3'd3;
   localparam logic [2:0] REG_START_X = 3'd4;
   localparam logic [2:0] REG_END_X   = 3'd5;

   typedef struct packed {
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic signed [31:0] d;
   } coef_type;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] p,
                                                  input logic signed [63:0] q);
      logic signed [63:0] s;
      s = p + q;
      if (p[63] == q[63] && s[63] != p[63]) sat_add = p[63] ? VAL_MIN : VAL_MAX;
      else sat_add = s;
   endfunction

   // magnitude as unsigned; the most negative value maps to 2^63
   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      logic signed [63:0] n;
      n = -v;
      mag64 = v[63] ? n : v;
   endfunction

   // magnitude of a value known to stay below 2^33 in size
   function automatic logic [32:0] mag34(input logic signed [33:0] v);
      logic signed [33:0] n;
      n = -v;
      mag34 = v[33] ? n[32:0] : v[32:0];
   endfunction

   function automatic logic signed [63:0] abs_sat(input logic signed [63:0] p);
      if (!p[63]) abs_sat = p;
      else if (p == VAL_MIN) abs_sat = VAL_MAX;
      else abs_sat = -p;
   endfunction

endpackage

// ----- rtl/core/cma_mulq.sv -----
// Q.16 product (a*b)>>>16 with saturation, three register stages.
module cma_mulq import cma_pkg::*; (
   input  logic               clock,
   input  logic [63:0]        a_mag,
   input  logic [32:0]        b_mag,
   input  logic               neg,
   output logic signed [63:0] res
);

   logic [64:0]        lo_ff, hi_ff;
   logic               neg1_ff, neg2_ff;
   logic [96:0]        prod_ff;
   logic [96:0]        prod_in;
   logic signed [63:0] res_ff, res_in;
   logic [80:0]        q;
   logic               inc;

   assign prod_in = {32'd0, lo_ff} + {hi_ff, 32'd0};

   always_comb begin
      // negative results round toward minus infinity
      inc = neg2_ff && (prod_ff[15:0] != 16'd0);
      q   = prod_ff[96:16] + 81'(inc);
      if (q[80:63] != 18'd0) res_in = neg2_ff ? VAL_MIN : VAL_MAX;
      else if (neg2_ff)       res_in = -$signed(q[63:0]);
      else                    res_in = $signed(q[63:0]);
   end

   always_ff @(posedge clock) begin
      lo_ff   <= 65'(a_mag[31:0] * b_mag);
      hi_ff   <= 65'(a_mag[63:32] * b_mag);
      neg1_ff <= neg;
      prod_ff <= prod_in;
      neg2_ff <= neg1_ff;
      res_ff  <= res_in;
   end

   assign res = res_ff;

endmodule

// ----- rtl/core/cma_eval.sv -----
// w * |a*x^3 + b*x^2 + c*x + d|, one sample per cycle.
module cma_eval import cma_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [33:0] x,
   input  coef_type           coef,
   input  logic signed [33:0] w,
   output logic               out_valid,
   output logic signed [63:0] out_prod,
   output logic               busy
);

   logic [EVAL_LAT-1:0] v_ff;
   logic signed [33:0]  x_d_ff [3];
   logic signed [63:0]  bx2_d_ff [3];
   logic signed [63:0]  cx_d_ff [4];
   logic signed [63:0]  x2, x3, bx2, cx, ax3;
   logic signed [63:0]  s1_ff, s2_ff, s3_ff, h_ff;

   cma_mulq u_xx (
      .clock(clock), .a_mag(64'(mag34(x))), .b_mag(mag34(x)), .neg(1'b0), .res(x2)
   );

   cma_mulq u_x3 (
      .clock(clock), .a_mag(mag64(x2)), .b_mag(mag34(x_d_ff[2])),
      .neg(x2[63] ^ x_d_ff[2][33]), .res(x3)
   );

   cma_mulq u_bx2 (
      .clock(clock), .a_mag(mag64(x2)), .b_mag(mag34(34'(coef.b))),
      .neg(x2[63] ^ coef.b[31]), .res(bx2)
   );

   cma_mulq u_cx (
      .clock(clock), .a_mag(64'(mag34(x_d_ff[2]))), .b_mag(mag34(34'(coef.c))),
      .neg(x_d_ff[2][33] ^ coef.c[31]), .res(cx)
   );

   cma_mulq u_ax3 (
      .clock(clock), .a_mag(mag64(x3)), .b_mag(mag34(34'(coef.a))),
      .neg(x3[63] ^ coef.a[31]), .res(ax3)
   );

   // height is never negative
   cma_mulq u_wh (
      .clock(clock), .a_mag(h_ff), .b_mag(mag34(w)), .neg(w[33]), .res(out_prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[EVAL_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      x_d_ff[0]   <= x;
      x_d_ff[1]   <= x_d_ff[0];
      x_d_ff[2]   <= x_d_ff[1];
      bx2_d_ff[0] <= bx2;
      bx2_d_ff[1] <= bx2_d_ff[0];
      bx2_d_ff[2] <= bx2_d_ff[1];
      cx_d_ff[0]  <= cx;
      cx_d_ff[1]  <= cx_d_ff[0];
      cx_d_ff[2]  <= cx_d_ff[1];
      cx_d_ff[3]  <= cx_d_ff[2];
      s1_ff       <= sat_add(ax3, bx2_d_ff[2]);
      s2_ff       <= sat_add(s1_ff, cx_d_ff[3]);
      s3_ff       <= sat_add(s2_ff, 64'(coef.d));
      h_ff        <= abs_sat(s3_ff);
   end

   assign out_valid = v_ff[EVAL_LAT-1];
   assign busy      = |v_ff;

endmodule

// ----- rtl/core/cubic_midpoint_area_core.sv -----
// Midpoint-rule area under |a*x^3+b*x^2+c*x+d| between start_x and end_x.
// Configuration: csr_* writes a register index and 32-bit Q16.16 data; always
// ready, write only while the block is idle.
// Request (req_*): tuser = mode, tdata = num_rects, correct_answer, precision.
// Response (rsp_*): tdata = area, rect_count, reached; tuser = status.
// One request is worked at a time. A pass over n rectangles runs the radix-2
// width divider, issues n samples into the 16-deep evaluation pipeline,
// drains it and takes its control steps. In mode 0 there are no compare
// steps and one output step; a zero count goes straight to the output step.
// Mode 1 repeats the pass for k = 1, 2, ... and stops at the first passing
// count, or when all 100 counts of the search fail.
// The next request is taken the cycle after the response is registered.
// Reset clears the configuration registers to zero and drops any transaction
// in flight. The result sits in an output register; a new request is taken
// while it waits, and a stalled receiver holds the block only when the next
// result is ready and the register is still full.
module cubic_midpoint_area_core import cma_pkg::*; #(
   parameter int MAX_RECTS    = MAX_RECTS_DEF,
   parameter int SEARCH_LIMIT = SEARCH_LIMIT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // num_rects[10:0], correct_answer[74:11], precision[122:75]
   input  logic         req_tuser,  // mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata,  // area[63:0], rect_count[74:64], reached[75]
   output logic         rsp_tuser   // status
);

   localparam int TOP_CNT = (MAX_RECTS > SEARCH_LIMIT + 1) ? MAX_RECTS : SEARCH_LIMIT + 1;
   localparam int C_W     = $clog2(TOP_CNT + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIV   = 4'd1;
   localparam logic [3:0] S_WSET  = 4'd2;
   localparam logic [3:0] S_XSET  = 4'd3;
   localparam logic [3:0] S_ISSUE = 4'd4;
   localparam logic [3:0] S_DRAIN = 4'd5;
   localparam logic [3:0] S_DIFF  = 4'd6;
   localparam logic [3:0] S_CMP   = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   coef_type           coef_ff;
   logic signed [31:0] start_ff, end_ff;

   logic [3:0]         state_ff;
   logic               mode_ff;
   logic signed [63:0] corr_ff;
   logic [47:0]        prec_ff;
   logic [C_W-1:0]     n_ff, i_ff;
   logic [32:0]        dq_ff;
   logic [C_W-1:0]     rem_ff;
   logic [5:0]         dcnt_ff;
   logic signed [33:0] w_ff, x_ff;
   logic signed [63:0] sum_ff;
   logic signed [64:0] diff_ff;
   logic               reached_ff, status_ff;

   logic               rsp_valid_ff;
   logic [79:0]        rsp_data_ff;
   logic               rsp_user_ff;

   logic signed [32:0] span;
   logic [32:0]        span_mag;
   logic [C_W:0]       r2;
   logic               ge;
   logic [64:0]        dabs;
   logic               pass;
   logic [10:0]        num_req;
   logic [C_W-1:0]     n_clamp;
   logic               ev_valid, ev_busy;
   logic signed [63:0] ev_prod;

   assign span     = 33'(end_ff) - 33'(start_ff);
   assign span_mag = span[32] ? 33'(-span) : span;
   assign r2       = {rem_ff, dq_ff[32]};
   assign ge       = r2 >= {1'b0, n_ff};
   assign dabs     = diff_ff[64] ? 65'(-diff_ff) : 65'(diff_ff);
   assign pass     = dabs <= 65'(prec_ff);
   assign num_req  = req_tdata[10:0];
   assign n_clamp  = (32'(num_req) > MAX_RECTS) ? C_W'(MAX_RECTS) : C_W'(num_req);

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);

   cma_eval u_eval (
      .clock(clock),
      .reset(reset),
      .in_valid(state_ff == S_ISSUE),
      .x(x_ff),
      .coef(coef_ff),
      .w(w_ff),
      .out_valid(ev_valid),
      .out_prod(ev_prod),
      .busy(ev_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff  <= '0;
         start_ff <= '0;
         end_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_COEF_A:  coef_ff.a <= csr_data;
            REG_COEF_B:  coef_ff.b <= csr_data;
            REG_COEF_C:  coef_ff.c <= csr_data;
            REG_COEF_D:  coef_ff.d <= csr_data;
            REG_START_X: start_ff  <= csr_data;
            REG_END_X:   end_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the output step sets the valid itself
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         if (ev_valid) sum_ff <= sat_add(sum_ff, ev_prod);

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  mode_ff    <= req_tuser;
                  corr_ff    <= req_tdata[74:11];
                  prec_ff    <= req_tdata[122:75];
                  reached_ff <= 1'b0;
                  if (!req_tuser && num_req == 11'd0) begin
                     n_ff      <= '0;
                     sum_ff    <= '0;
                     status_ff <= 1'b1;
                     state_ff  <= S_OUT;
                  end else begin
                     n_ff      <= req_tuser ? C_W'(1) : n_clamp;
                     status_ff <= 1'b0;
                     dq_ff     <= span_mag;
                     rem_ff    <= '0;
                     dcnt_ff   <= 6'd32;
                     state_ff  <= S_DIV;
                  end
               end
            end
            S_DIV: begin
               rem_ff  <= ge ? C_W'(r2 - {1'b0, n_ff}) : r2[C_W-1:0];
               dq_ff   <= {dq_ff[31:0], ge};
               dcnt_ff <= dcnt_ff - 6'd1;
               if (dcnt_ff == 6'd0) state_ff <= S_WSET;
            end
            S_WSET: begin
               // truncation toward zero: quotient of magnitudes, sign of the span
               w_ff     <= span[32] ? -$signed({1'b0, dq_ff}) : $signed({1'b0, dq_ff});
               state_ff <= S_XSET;
            end
            S_XSET: begin
               x_ff     <= 34'(start_ff) + (w_ff >>> 1);
               i_ff     <= '0;
               sum_ff   <= '0;
               state_ff <= S_ISSUE;
            end
            S_ISSUE: begin
               x_ff <= x_ff + w_ff;
               i_ff <= i_ff + 1'b1;
               if (C_W'(i_ff + 1'b1) == n_ff) state_ff <= S_DRAIN;
            end
            S_DRAIN: begin
               if (!ev_busy) state_ff <= mode_ff ? S_DIFF : S_OUT;
            end
            S_DIFF: begin
               diff_ff  <= 65'(sum_ff) - 65'(corr_ff);
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (pass) begin
                  reached_ff <= 1'b1;
                  state_ff   <= S_OUT;
               end else if (n_ff == C_W'(SEARCH_LIMIT)) begin
                  n_ff     <= C_W'(SEARCH_LIMIT + 1);
                  state_ff <= S_OUT;
               end else begin
                  n_ff     <= n_ff + 1'b1;
                  dq_ff    <= span_mag;
                  rem_ff   <= '0;
                  dcnt_ff  <= 6'd32;
                  state_ff <= S_DIV;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {4'd0, reached_ff, 11'(n_ff), sum_ff};
                  rsp_user_ff  <= status_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- rtl/core/cma_checker.sv -----
module cma_checker import cma_pkg::*; #(
   parameter int SEARCH_LIMIT = SEARCH_LIMIT_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // zero-count status carries nothing else
   a_zero_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[75:0] == 76'd0)
      else $error("zero-count response not clean");

   a_reached_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[75] |->
         rsp_tdata[74:64] != 11'd0 && rsp_tdata[74:64] <= 11'(SEARCH_LIMIT) && !rsp_tuser)
      else $error("reached with bad count");

   a_ok_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[74:64] != 11'd0)
      else $error("ok response with zero count");

endmodule

bind cubic_midpoint_area_core cma_checker #(.SEARCH_LIMIT(SEARCH_LIMIT)) u_cma_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench import cma_pkg::*; ();

   localparam logic MODE_AREA   = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;
   localparam logic ST_OK       = 1'b0;
   localparam logic ST_ZERO     = 1'b1;
   localparam logic [2:0] REG_NONE = 3'd7;
   localparam int LIMIT_RECTS  = 1024;
   localparam int SEARCH_MAX   = 100;
   localparam int IDLE_LIMIT   = 40000;

   typedef struct {
      longint     area;
      logic [10:0] count;
      logic       reached;
      logic       status;
   } area_result_type;

   typedef struct {
      logic        mode;
      logic [10:0] nrect;
      logic [63:0] answer;
      logic [47:0] prec;
      bit          typed;
      area_result_type res;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_index;
   logic [31:0]  csr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [79:0]  rsp_tdata;
   logic         rsp_tuser;

   // shadow of the configuration registers
   longint k_a, k_b, k_c, k_d, x_lo, x_hi;

   area_result_type pending_areas[$];
   int errors;
   int hold_cycles;
   int burst_left;

   cubic_midpoint_area_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Q.16 product, floor shift, saturated
   function automatic longint qmul(input longint p, input longint q);
      logic signed [127:0] wa, wb, pr;
      wa = p;
      wb = q;
      pr = (wa * wb) >>> 16;
      if (pr[127:63] != {65{pr[127]}}) return pr[127] ? VAL_MIN : VAL_MAX;
      return pr[63:0];
   endfunction

   function automatic longint qadd(input longint p, input longint q);
      logic signed [64:0] s;
      s = {p[63], p} + {q[63], q};
      if (s[64] != s[63]) return s[64] ? VAL_MIN : VAL_MAX;
      return s[63:0];
   endfunction

   function automatic longint poly_height(input longint x);
      longint x2, x3, p;
      x2 = qmul(x, x);
      x3 = qmul(x2, x);
      p = qadd(qmul(k_a, x3), qmul(k_b, x2));
      p = qadd(p, qmul(k_c, x));
      p = qadd(p, k_d);
      if (p < 0) p = (p == VAL_MIN) ? VAL_MAX : -p;
      return p;
   endfunction

   function automatic longint midpoint_area(input longint n);
      longint w, half, sum;
      w = (x_hi - x_lo) / n;
      half = w >>> 1;
      sum = 0;
      for (longint i = 0; i < n; i++)
         sum = qadd(sum, qmul(w, poly_height(x_lo + i * w + half)));
      return sum;
   endfunction

   function automatic area_result_type predict_area(input logic mode, input logic [10:0] nrect,
                                                    input logic [63:0] answer,
                                                    input logic [47:0] prec);
      area_result_type r;
      logic signed [65:0] diff;
      r = '{0, 11'd0, 1'b0, ST_OK};
      if (mode == MODE_AREA) begin
         if (nrect == 0) r.status = ST_ZERO;
         else begin
            r.count = (nrect > LIMIT_RECTS) ? 11'(LIMIT_RECTS) : nrect;
            r.area = midpoint_area(r.count);
         end
      end else begin
         r.count = 11'(SEARCH_MAX + 1);
         for (int k = 1; k <= SEARCH_MAX; k++) begin
            r.area = midpoint_area(k);
            diff = $signed({{2{r.area[63]}}, r.area}) - $signed({{2{answer[63]}}, answer});
            if (diff < 0) diff = -diff;
            if (diff <= $signed({18'd0, prec})) begin
               r.count = 11'(k);
               r.reached = 1'b1;
               break;
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // response side: check, then set up tready for the next edge
   initial begin
      int cyc, per, duty;
      area_result_type e;
      cyc = 0; per = 1; duty = 1;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_areas.size() == 0) report_mismatch("unexpected transaction", 0, 0);
            else begin
               e = pending_areas.pop_front();
               if (rsp_tdata[63:0] !== e.area) report_mismatch("area", rsp_tdata[63:0], e.area);
               if (rsp_tdata[74:64] !== e.count)
                  report_mismatch("rect_count", rsp_tdata[74:64], e.count);
               if (rsp_tdata[75] !== e.reached)
                  report_mismatch("reached", rsp_tdata[75], e.reached);
               if (rsp_tuser !== e.status) report_mismatch("status", rsp_tuser, e.status);
            end
         end
         cyc++;
         if (cyc % 600 == 0) begin
            per = $urandom_range(1, 9);
            duty = ($urandom_range(0, 3) == 0) ? per : $urandom_range(1, per);
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else rsp_tready <= (cyc % per) < duty;
      end
   end

   // watchdog on cycles with no transaction on any channel
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) quiet = 0;
         else quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("** cubic_midpoint_area_core: FAILED **");
            $finish;
         end
      end
   end

   task automatic send_item(input logic mode, input logic [10:0] nrect,
                            input logic [63:0] answer, input logic [47:0] prec,
                            input bit typed, input area_result_type res);
      int gap;
      pending_areas.push_back(typed ? res : predict_area(mode, nrect, answer, prec));
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {5'd0, prec, answer, nrect};
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(1, 10);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_areas.size() != 0) @(posedge clock);
      repeat (EVAL_LAT + 8) @(posedge clock);
   endtask

   task automatic write_regs(input logic [31:0] v[6], input bit with_stray);
      logic [2:0] idx[7];
      logic [31:0] val[7];
      int cnt;
      idx = '{REG_COEF_A, REG_COEF_B, REG_COEF_C, REG_COEF_D, REG_START_X, REG_END_X,
              REG_NONE};
      for (int i = 0; i < 6; i++) val[i] = v[i];
      val[6] = $urandom;
      cnt = with_stray ? 7 : 6;
      for (int i = 0; i < cnt; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         do @(posedge clock); while (!csr_ready);
         case (idx[i])
            REG_COEF_A:  k_a = $signed(val[i]);
            REG_COEF_B:  k_b = $signed(val[i]);
            REG_COEF_C:  k_c = $signed(val[i]);
            REG_COEF_D:  k_d = $signed(val[i]);
            REG_START_X: x_lo = $signed(val[i]);
            REG_END_X:   x_hi = $signed(val[i]);
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] near_q16(input int mag);
      return 32'($signed($urandom_range(0, 2 * mag)) - mag);
   endfunction

   task automatic random_item();
      area_result_type none;
      int sel, k;
      longint off;
      logic [47:0] prec;
      logic [10:0] n;
      none = '{0, 11'd0, 1'b0, ST_OK};
      sel = $urandom_range(0, 19);
      if (sel < 11) begin
         n = ($urandom_range(0, 15) == 0) ? 11'($urandom_range(41, 2047))
                                          : 11'($urandom_range(1, 40));
         if (sel == 0) n = 11'd0;
         send_item(MODE_AREA, n, {$urandom, $urandom}, 48'($urandom), 0, none);
      end else if (sel < 18) begin
         // search aimed at a count reachable in a few passes
         k = $urandom_range(1, 12);
         prec = 48'($urandom_range(0, 4000));
         off = longint'($urandom_range(0, 2 * prec)) - longint'(prec);
         send_item(MODE_SEARCH, 11'($urandom), midpoint_area(k) + off, prec, 0, none);
      end else begin
         send_item(MODE_SEARCH, 11'($urandom), {$urandom, $urandom},
                   {16'($urandom), 32'($urandom)}, 0, none);
      end
   endtask

   initial begin
      stim_row_type rows[$];
      logic [31:0] cfg[6];
      errors = 0;
      hold_cycles = 0;
      burst_left = 0;
      k_a = 0; k_b = 0; k_c = 0; k_d = 0; x_lo = 0; x_hi = 0;
      reset = 1'b1;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = MODE_AREA;

      // all registers zero after reset: every area is zero
      rows = '{
         '{MODE_AREA, 11'd1, 64'd0, 48'd0, 1, '{0, 11'd1, 1'b0, ST_OK}},
         '{MODE_AREA, 11'd0, 64'd0, 48'd0, 1, '{0, 11'd0, 1'b0, ST_ZERO}},
         '{MODE_AREA, 11'd0, '1, '1, 1, '{0, 11'd0, 1'b0, ST_ZERO}},
         '{MODE_AREA, 11'd1024, 64'd0, 48'd0, 1, '{0, 11'd1024, 1'b0, ST_OK}},
         '{MODE_AREA, 11'd1025, 64'd0, 48'd0, 1, '{0, 11'd1024, 1'b0, ST_OK}},
         '{MODE_AREA, 11'd2047, '1, '1, 1, '{0, 11'd1024, 1'b0, ST_OK}},
         '{MODE_SEARCH, 11'd0, 64'd0, 48'd0, 1, '{0, 11'd1, 1'b1, ST_OK}},
         '{MODE_SEARCH, 11'd2047, 64'd1, 48'd1, 1, '{0, 11'd1, 1'b1, ST_OK}},
         '{MODE_SEARCH, 11'd5, VAL_MAX, 48'd0, 1, '{0, 11'd101, 1'b0, ST_OK}},
         '{MODE_SEARCH, 11'd5, VAL_MIN, '1, 1, '{0, 11'd101, 1'b0, ST_OK}},
         '{MODE_SEARCH, 11'd0, VAL_MIN + 1, 48'd0, 0, '{0, 11'd0, 1'b0, ST_OK}},
         '{MODE_AREA, 11'd7, 64'h5555_5555_5555_5555, 48'hAAAA_AAAA_AAAA, 0,
           '{0, 11'd0, 1'b0, ST_OK}},
         '{MODE_AREA, 11'h2AA, 64'hAAAA_AAAA_AAAA_AAAA, 48'h5555_5555_5555, 0,
           '{0, 11'd0, 1'b0, ST_OK}}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i])
         send_item(rows[i].mode, rows[i].nrect, rows[i].answer, rows[i].prec,
                   rows[i].typed, rows[i].res);
      settle();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: cfg = '{32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0, 32'h000A_0000};
            1: cfg = '{near_q16(4 << 16), near_q16(4 << 16), near_q16(4 << 16),
                       near_q16(4 << 16), 32'hFFFE_0000, 32'h0003_0000};
            2: cfg = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h7FFF_FFFF};
            3: cfg = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h8000_0000};
            4: cfg = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            default: cfg = '{near_q16(1 << 18), near_q16(1 << 18), near_q16(1 << 18),
                             near_q16(1 << 20), 32'h0005_0000, near_q16(1 << 18)};
         endcase
         write_regs(cfg, ph == 4);
         // long receiver hold-off while requests keep coming
         if (ph == 1) hold_cycles = 3000;
         repeat (17) random_item();
         settle();
      end

      if (errors == 0) $display("** cubic_midpoint_area_core: PASSED **");
      else $display("** cubic_midpoint_area_core: FAILED **");
      $finish;
   end

endmodule
